### rtl/tmps_pkg.sv
package tmps_pkg;

  // Row store depth: the largest triangle held, in rows
  localparam int MAX_ROWS = 256;
  // Column and row counter width
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  // Field widths
  localparam int ROWCNT_W = 9;
  localparam int VAL_W    = 16;
  localparam int SUM_W    = 25;
  localparam int OUT_W    = 24;

  // Running minimum start value: largest positive 25-bit partial sum of 24 bits
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(25'h0FF_FFFF);

  // Stage-1 control flags for one entry
  typedef struct packed {
    logic first_row;  // entry sits in row zero
    logic col_zero;   // leftmost column, right parent only
    logic diag;       // last column of its row, left parent only
    logic last_row;   // entry sits in the final row
  } entry_flags_t;

endpackage

### rtl/triangle_min_path_sum_unit.sv
// Triangle minimum path sum, row-by-row dynamic programming over a row store.
// Throughput: one entry per cycle, but for the stall below; the final entry's
// min_path_sum reaches m_axis via the row store read, then add and compare.
// A finishing entry stalls only while an unclaimed result is not taken that cycle.
// Reset (rst, synchronous): counters, left parent and running minimum rearm,
// row_count acts as 1; the row store is not cleared and needs no clearing pass.
module triangle_min_path_sum_unit (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration: row_count
  input  logic                          row_count_wr_en,
  input  logic [tmps_pkg::ROWCNT_W-1:0] row_count_wr_data,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,   // [15:0] entry_value
  // Output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata    // [23:0] min_path_sum
);

  localparam int ROW_W = tmps_pkg::ROW_W;
  localparam int SUM_W = tmps_pkg::SUM_W;
  localparam int VAL_W = tmps_pkg::VAL_W;
  localparam int OUT_W = tmps_pkg::OUT_W;

  // Row store of best partial sums
  logic signed [SUM_W-1:0] best_sums [tmps_pkg::MAX_ROWS];
  logic signed [SUM_W-1:0] rd_data;

  // Control state
  logic [ROW_W-1:0]        row_index;
  logic [ROW_W-1:0]        column_index;
  logic [ROW_W-1:0]        last_row;
  logic signed [SUM_W-1:0] left_parent_sum;
  logic signed [SUM_W-1:0] running_minimum;

  // Stage 1 (after the store read)
  logic                    s1_valid;
  tmps_pkg::entry_flags_t  s1_flags;
  logic [ROW_W-1:0]        s1_col;
  logic signed [VAL_W-1:0] s1_value;
  logic                    s1_bypass;
  logic signed [SUM_W-1:0] s1_fwd;

  // Output register
  logic                    out_valid;
  logic [OUT_W-1:0]        out_data;

  logic                    accept;
  logic                    s1_emit;
  logic                    s1_advance;
  logic                    in_diag;
  logic                    in_last;
  logic signed [SUM_W-1:0] entry_ext;
  logic signed [SUM_W-1:0] above;
  logic signed [SUM_W-1:0] parent_min;
  logic signed [SUM_W-1:0] path_sum;
  logic signed [SUM_W-1:0] min_next;
  logic [ROW_W-1:0]        last_row_next;

  // Handshake; a finishing entry waits only on a full output register not drained this cycle
  assign s1_emit       = s1_flags.diag && s1_flags.last_row;
  assign s1_advance    = s1_valid && (!s1_emit || !out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || !s1_emit || !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign in_diag = (column_index == row_index);
  assign in_last = (row_index == last_row);

  // Row store: read the right parent at accept, write the new sum in stage 1
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= best_sums[column_index];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      best_sums[s1_col] <= path_sum;
    end
  end

  // Stage 1 payload and forwarding of a same-column write
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flags.first_row <= (row_index == '0);
      s1_flags.col_zero  <= (column_index == '0);
      s1_flags.diag      <= in_diag;
      s1_flags.last_row  <= in_last;
      s1_col             <= column_index;
      s1_value           <= s_axis_tdata;
      s1_bypass          <= s1_valid && (s1_col == column_index);
      s1_fwd             <= path_sum;
    end
  end

  // Add-compare for the current entry
  always_comb begin
    entry_ext  = {{(SUM_W-VAL_W){s1_value[VAL_W-1]}}, s1_value};
    above      = s1_flags.diag ? '0 : (s1_bypass ? s1_fwd : rd_data);
    parent_min = (left_parent_sum < above) ? left_parent_sum : above;
    if (s1_flags.first_row) begin
      path_sum = entry_ext;
    end else if (s1_flags.col_zero) begin
      path_sum = above + entry_ext;
    end else if (s1_flags.diag) begin
      path_sum = left_parent_sum + entry_ext;
    end else begin
      path_sum = parent_min + entry_ext;
    end
    min_next = running_minimum;
    if (s1_flags.last_row && (path_sum < running_minimum)) begin
      min_next = path_sum;
    end
  end

  // Final row index from the written row count, clamped to the store depth
  always_comb begin
    if (row_count_wr_data == '0) begin
      last_row_next = '0;
    end else if (32'(row_count_wr_data) > tmps_pkg::MAX_ROWS) begin
      last_row_next = ROW_W'(tmps_pkg::MAX_ROWS - 1);
    end else begin
      last_row_next = ROW_W'(row_count_wr_data - 1'b1);
    end
  end

  // Counters, left parent, running minimum, valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      row_index       <= '0;
      column_index    <= '0;
      last_row        <= '0;
      left_parent_sum <= '0;
      running_minimum <= tmps_pkg::SUM_MAX;
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
    end else if (row_count_wr_en) begin
      row_index       <= '0;
      column_index    <= '0;
      last_row        <= last_row_next;
      left_parent_sum <= '0;
      running_minimum <= tmps_pkg::SUM_MAX;
    end else begin
      // row/column walk at accept
      if (accept) begin
        if (in_diag) begin
          column_index <= '0;
          row_index    <= in_last ? '0 : row_index + 1'b1;
        end else begin
          column_index <= column_index + 1'b1;
        end
      end

      // stage 1 retire
      if (s1_advance) begin
        if (s1_emit) begin
          left_parent_sum <= '0;
          running_minimum <= tmps_pkg::SUM_MAX;
        end else begin
          left_parent_sum <= above;
          running_minimum <= min_next;
        end
      end

      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end

      // output transaction
      if (s1_advance && s1_emit) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_emit) begin
      out_data <= min_next[OUT_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

`ifndef NO_ASSERTIONS
  // The column walk never passes the diagonal
  assert property (@(posedge clk) disable iff (rst) column_index <= row_index)
    else $error("column index beyond row index");

  // The row walk never passes the final row
  assert property (@(posedge clk) disable iff (rst) row_index <= last_row)
    else $error("row index beyond final row");

  // A result never overwrites an unclaimed one
  assert property (@(posedge clk) disable iff (rst)
    (s1_advance && s1_emit) |-> (!out_valid || m_axis_tready))
    else $error("result issued into full output register");

  // Back-to-back same-column access only happens at column zero
  assert property (@(posedge clk) disable iff (rst)
    (accept && s1_valid && (s1_col == column_index)) |-> (column_index == '0))
    else $error("unexpected same-column forwarding");
`endif

endmodule
